[hw/rtl/alci_pkg.sv]
// Shared types, constants and field layout of the arc-length curve interpolator.
// No dependencies; every other file of the block but alci_ram imports this package.
`timescale 1ns / 1ps

package alci_pkg;

   localparam int MAX_POINTS = 256;
   localparam int FRAC_BITS  = 16;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int PT_W       = 32;
   localparam int LEN_W      = 42;
   localparam int ENTRY_W    = 2 * PT_W + LEN_W;
   localparam int HALF_W     = (LEN_W + 1) / 2;
   localparam int PP_W       = PT_W + HALF_W;
   localparam int PROD_W     = 2 * PT_W;
   localparam int NUM_W      = PT_W + LEN_W;
   localparam int SQ_IN_W    = 2 * PT_W + 1;
   localparam int SQ_ROOT_W  = PT_W + 1;
   localparam int SQ_REM_W   = SQ_ROOT_W + 4;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 1;

   localparam int REQ_TDATA_W = 3 * PT_W;
   localparam int RSP_LEN_LSB = 2 * PT_W;
   localparam int RSP_CNT_LSB = 2 * PT_W + LEN_W;
   localparam int RSP_USED_W  = RSP_CNT_LSB + CNT_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [LEN_W-1:0] LEN_MAX        = {LEN_W{1'b1}};
   localparam logic [PT_W-1:0]  RANGE_STOP_RST = PT_W'(64'd1 << FRAC_BITS);

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_EVAL   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_RANGE = 3'd1,
      ST_FEW   = 3'd2,
      ST_FULL  = 3'd3,
      ST_SPAN  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_START = 1'b0,
      CSR_RANGE_STOP  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic wide;
   } div_ctl_type;

endpackage

[hw/rtl/alci_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module alci_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/alci_sqrt.sv]
// Bit-serial floor square root, one result bit per cycle.
// Depends on alci_pkg.
`timescale 1ns / 1ps

module alci_sqrt
   import alci_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_IN_W-1:0]   radicand,
   output logic                 done,
   output logic [SQ_ROOT_W-1:0] root
);

   localparam int PAIR_W = 2 * SQ_ROOT_W;
   localparam int SC_W   = $clog2(SQ_ROOT_W + 1);

   logic [PAIR_W-1:0]    val_ff;
   logic [SQ_REM_W-1:0]  rem_ff;
   logic [SQ_ROOT_W-1:0] root_ff;
   logic [SC_W-1:0]      cnt_ff;
   logic                 done_ff;
   logic [SQ_REM_W-1:0]  rem_sh;
   logic [SQ_REM_W-1:0]  trial;

   assign rem_sh = {rem_ff[SQ_REM_W-3:0], val_ff[PAIR_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            val_ff  <= PAIR_W'(radicand);
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= SC_W'(SQ_ROOT_W);
         end else if (cnt_ff != '0) begin
            val_ff <= {val_ff[PAIR_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[SQ_ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[SQ_ROOT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == SC_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/alci_div.sv]
// Restoring divider, one quotient bit per cycle; 42 or 32 quotient bits.
// Depends on alci_pkg.
`timescale 1ns / 1ps

module alci_div
   import alci_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [NUM_W-1:0]  num,
   input  logic [LEN_W-1:0]  den,
   output logic              done,
   output logic [LEN_W-1:0]  quot
);

   localparam int DC_W = $clog2(LEN_W + 1);

   logic [LEN_W-1:0] rem_ff;
   logic [LEN_W-1:0] sh_ff;
   logic [LEN_W-1:0] quot_ff;
   logic [DC_W-1:0]  cnt_ff;
   logic             done_ff;
   logic [LEN_W:0]   trial;

   assign trial = {rem_ff, sh_ff[LEN_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            quot_ff <= '0;
            // the quotient is known to fit, so the top bits start as remainder
            if (ctl.wide) begin
               rem_ff <= LEN_W'(num[NUM_W-1:LEN_W]);
               sh_ff  <= num[LEN_W-1:0];
               cnt_ff <= DC_W'(LEN_W);
            end else begin
               rem_ff <= num[NUM_W-1:PT_W];
               sh_ff  <= {num[PT_W-1:0], (LEN_W - PT_W)'(0)};
               cnt_ff <= DC_W'(PT_W);
            end
         end else if (cnt_ff != '0) begin
            sh_ff <= {sh_ff[LEN_W-2:0], 1'b0};
            if (trial >= {1'b0, den}) begin
               rem_ff  <= LEN_W'(trial - {1'b0, den});
               quot_ff <= {quot_ff[LEN_W-2:0], 1'b1};
            end else begin
               rem_ff  <= trial[LEN_W-1:0];
               quot_ff <= {quot_ff[LEN_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DC_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hw/rtl/arc_length_curve_interpolator_unit.sv]
// Top level of the arc-length curve interpolator: control sequencer and datapath.
// Depends on alci_pkg, alci_ram, alci_sqrt and alci_div.
`timescale 1ns / 1ps

// Holds up to MAX_POINTS complex points with their cumulative arc length in one
// synchronous RAM (entry = real, imag, length). One item is worked on at a time;
// each item gives exactly one result item. An append after the first runs one RAM
// read, two squarings and the bit-serial square root (33 steps). Evaluate runs a
// 42-step division for the arc position, a binary search of up to nine RAM probes,
// then, unless the search picks the last point, two 32-step divisions for the real
// and imaginary interpolation. Clear, no-op and any error go straight to the result
// stage. A new item is taken while the previous result still waits at the output
// register. The user must write range_start/range_stop only while idle; the block
// does not enforce it. The smaller of the two is used as the start.

module arc_length_curve_interpolator_unit
   import alci_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // point_real, point_imag, param_value (from bit 0 up)
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // value_real, value_imag, total_length, point_count, zero fill (from bit 0 up)
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [PT_W-1:0]        csr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_APP_RD, S_SQX, S_SQY, S_SUM, S_SQRT, S_WRITE,
      S_MUL0, S_MUL1, S_MUL2, S_DIV, S_SRCH, S_SRCH_CMP,
      S_LAST, S_P0, S_P1, S_DONE
   } state_type;

   typedef enum logic [1:0] {PH_POS, PH_RE, PH_IM} phase_type;

   function automatic logic [PT_W:0] sdiff(input logic [PT_W-1:0] a, input logic [PT_W-1:0] b);
      return {a[PT_W-1], a} - {b[PT_W-1], b};
   endfunction

   function automatic logic [PT_W-1:0] mag_of(input logic [PT_W:0] d);
      logic [PT_W:0] n;
      n = -d;
      return d[PT_W] ? n[PT_W-1:0] : d[PT_W-1:0];
   endfunction

   function automatic logic dx_p1_sign(input logic [PT_W-1:0] a, input logic [PT_W-1:0] b);
      logic [PT_W:0] d;
      d = sdiff(a, b);
      return d[PT_W];
   endfunction

   state_type            state_ff;
   phase_type            phase_ff;
   status_type           status_ff;
   logic [PT_W-1:0]      start_ff, stop_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [LEN_W-1:0]     run_len_ff;
   logic [PT_W-1:0]      re_in_ff, im_in_ff;
   logic [PT_W-1:0]      ax_ff, ay_ff;
   logic [PROD_W-1:0]    sx_ff, sy_ff;
   logic [SQ_IN_W-1:0]   rad_ff;
   logic                 sq_start_ff, div_start_ff;
   logic [PT_W-1:0]      mul_a_ff;
   logic [LEN_W-1:0]     mul_b_ff;
   logic [PP_W-1:0]      pp_ff;
   logic [NUM_W-1:0]     acc_ff;
   logic [LEN_W-1:0]     den_ff, s_ff, c0_ff;
   logic [CNT_W-1:0]     a_ff, b_ff;
   logic [PT_W-1:0]      p0re_ff, p0im_ff, p1im_ff;
   logic                 sign_ff;
   logic [PT_W-1:0]      res_re_ff, res_im_ff;
   logic                 rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]  rsp_user_ff;

   // RAM and unit hookups
   logic                 wr_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]   wr_data, rd_data;
   logic [PT_W-1:0]      rd_re, rd_im;
   logic [LEN_W-1:0]     rd_len;
   logic                 sq_done, div_done;
   logic [SQ_ROOT_W-1:0] sq_root;
   logic [LEN_W-1:0]     quot;
   div_ctl_type          div_ctl;

   // datapath helpers
   logic [PT_W-1:0]      mul_x, mul_y;
   logic [PROD_W-1:0]    prod;
   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid, last_idx, a_dec;
   logic                 pick_last;
   logic [PT_W:0]        dx, dy, d_im;
   logic [LEN_W:0]       len_sum;
   logic [PT_W-1:0]      q_lo, interp_val;
   logic signed [PT_W-1:0] x_s, lo_s, hi_s;
   logic [PT_W:0]        x_off, span;
   opcode_type           req_op;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_op     = opcode_type'(req_tuser);

   assign rd_re  = rd_data[PT_W-1:0];
   assign rd_im  = rd_data[2*PT_W-1:PT_W];
   assign rd_len = rd_data[ENTRY_W-1:2*PT_W];

   assign wr_en   = (state_ff == S_WRITE);
   assign wr_data = {run_len_ff, im_in_ff, re_in_ff};

   assign mid_sum   = {1'b0, a_ff} + {1'b0, b_ff};
   assign mid       = mid_sum[CNT_W:1];
   assign last_idx  = count_ff - 1'b1;
   assign a_dec     = a_ff - 1'b1;
   assign pick_last = (a_ff >= count_ff) || (a_ff == '0);

   always_comb begin
      rd_addr = last_idx[ADDR_W-1:0];
      case (state_ff)
         S_SRCH: begin
            if (a_ff < b_ff)     rd_addr = mid[ADDR_W-1:0];
            else if (pick_last)  rd_addr = last_idx[ADDR_W-1:0];
            else                 rd_addr = a_dec[ADDR_W-1:0];
         end
         S_P0:    rd_addr = a_ff[ADDR_W-1:0];
         default: rd_addr = last_idx[ADDR_W-1:0];
      endcase
   end

   // one shared 32x32 multiplier: squares for append, partial products for evaluate
   always_comb begin
      case (state_ff)
         S_SQX: begin
            mul_x = ax_ff;
            mul_y = ax_ff;
         end
         S_SQY: begin
            mul_x = ay_ff;
            mul_y = ay_ff;
         end
         S_MUL0: begin
            mul_x = mul_a_ff;
            mul_y = PT_W'(mul_b_ff[HALF_W-1:0]);
         end
         default: begin
            mul_x = mul_a_ff;
            mul_y = PT_W'(mul_b_ff[LEN_W-1:HALF_W]);
         end
      endcase
   end
   assign prod = mul_x * mul_y;

   assign dx      = sdiff(re_in_ff, rd_re);
   assign dy      = sdiff(im_in_ff, rd_im);
   assign d_im    = sdiff(p1im_ff, p0im_ff);
   assign len_sum = {1'b0, run_len_ff} + (LEN_W + 1)'(sq_root);
   assign q_lo    = quot[PT_W-1:0];

   always_comb begin
      if (phase_ff == PH_RE) interp_val = sign_ff ? p0re_ff - q_lo : p0re_ff + q_lo;
      else                   interp_val = sign_ff ? p0im_ff - q_lo : p0im_ff + q_lo;
   end

   // parameter range with start and stop put in order
   assign x_s   = $signed(req_tdata[3*PT_W-1:2*PT_W]);
   assign lo_s  = ($signed(stop_ff) < $signed(start_ff)) ? $signed(stop_ff) : $signed(start_ff);
   assign hi_s  = ($signed(stop_ff) < $signed(start_ff)) ? $signed(start_ff) : $signed(stop_ff);
   assign x_off = sdiff(x_s, lo_s);
   assign span  = sdiff(hi_s, lo_s);

   assign div_ctl.start = div_start_ff;
   assign div_ctl.wide  = (phase_ff == PH_POS);

   alci_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   alci_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start_ff),
      .radicand (rad_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   alci_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (acc_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_POS;
         status_ff    <= ST_OK;
         start_ff     <= '0;
         stop_ff      <= RANGE_STOP_RST;
         count_ff     <= '0;
         run_len_ff   <= '0;
         sq_start_ff  <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_start_ff  <= 1'b0;
         div_start_ff <= 1'b0;

         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_RANGE_START: start_ff <= csr_data;
               CSR_RANGE_STOP:  stop_ff  <= csr_data;
               default: ;
            endcase
         end

         // the result stage reloads the register itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  re_in_ff  <= req_tdata[PT_W-1:0];
                  im_in_ff  <= req_tdata[2*PT_W-1:PT_W];
                  res_re_ff <= '0;
                  res_im_ff <= '0;
                  status_ff <= ST_OK;
                  phase_ff  <= PH_POS;
                  state_ff  <= S_DONE;
                  case (req_op)
                     OP_APPEND: begin
                        if (count_ff >= CNT_W'(MAX_POINTS)) status_ff <= ST_FULL;
                        else if (count_ff == '0)            state_ff  <= S_WRITE;
                        else                                state_ff  <= S_APP_RD;
                     end
                     OP_CLEAR: begin
                        count_ff   <= '0;
                        run_len_ff <= '0;
                     end
                     OP_EVAL: begin
                        if (lo_s == hi_s) begin
                           status_ff <= ST_SPAN;
                        end else if (count_ff < CNT_W'(2) || run_len_ff == '0) begin
                           status_ff <= ST_FEW;
                        end else if (x_s < lo_s || x_s > hi_s) begin
                           status_ff <= ST_RANGE;
                        end else begin
                           mul_a_ff <= x_off[PT_W-1:0];
                           mul_b_ff <= run_len_ff;
                           den_ff   <= LEN_W'(span[PT_W-1:0]);
                           state_ff <= S_MUL0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_APP_RD: begin
               ax_ff    <= mag_of(dx);
               ay_ff    <= mag_of(dy);
               state_ff <= S_SQX;
            end
            S_SQX: begin
               sx_ff    <= prod;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               sy_ff    <= prod;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               rad_ff      <= {1'b0, sx_ff} + {1'b0, sy_ff};
               sq_start_ff <= 1'b1;
               state_ff    <= S_SQRT;
            end
            S_SQRT: begin
               if (sq_done) begin
                  run_len_ff <= len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
                  state_ff   <= S_WRITE;
               end
            end
            S_WRITE: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_MUL0: begin
               pp_ff    <= prod[PP_W-1:0];
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               acc_ff   <= NUM_W'(pp_ff);
               pp_ff    <= prod[PP_W-1:0];
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               acc_ff       <= acc_ff + {pp_ff, HALF_W'(0)};
               div_start_ff <= 1'b1;
               state_ff     <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  case (phase_ff)
                     PH_POS: begin
                        s_ff     <= quot;
                        a_ff     <= '0;
                        b_ff     <= count_ff;
                        state_ff <= S_SRCH;
                     end
                     PH_RE: begin
                        res_re_ff <= interp_val;
                        sign_ff   <= d_im[PT_W];
                        mul_a_ff  <= mag_of(d_im);
                        phase_ff  <= PH_IM;
                        state_ff  <= S_MUL0;
                     end
                     default: begin
                        res_im_ff <= interp_val;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end
            S_SRCH: begin
               if (a_ff < b_ff)     state_ff <= S_SRCH_CMP;
               else if (pick_last)  state_ff <= S_LAST;
               else                 state_ff <= S_P0;
               if (a_ff < b_ff) begin
                  b_ff <= b_ff;
               end
            end
            S_SRCH_CMP: begin
               // probe address was mid of the current bounds, which are unchanged
               if (rd_len > s_ff) b_ff <= mid;
               else               a_ff <= mid + 1'b1;
               state_ff <= S_SRCH;
            end
            S_LAST: begin
               res_re_ff <= rd_re;
               res_im_ff <= rd_im;
               state_ff  <= S_DONE;
            end
            S_P0: begin
               p0re_ff  <= rd_re;
               p0im_ff  <= rd_im;
               c0_ff    <= rd_len;
               state_ff <= S_P1;
            end
            S_P1: begin
               den_ff   <= rd_len - c0_ff;
               mul_b_ff <= s_ff - c0_ff;
               sign_ff  <= dx_p1_sign(rd_re, p0re_ff);
               mul_a_ff <= mag_of(sdiff(rd_re, p0re_ff));
               p1im_ff  <= rd_im;
               phase_ff <= PH_RE;
               state_ff <= S_MUL0;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_TDATA_W'({count_ff, run_len_ff, res_im_ff, res_re_ff});
                  rsp_user_ff  <= status_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hw/rtl/alci_checker.sv]
// Port-level checks for the arc-length curve interpolator, bound to the top level.
// Depends on alci_pkg and arc_length_curve_interpolator_unit.
`timescale 1ns / 1ps

module alci_checker
   import alci_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_CNT_LSB +: CNT_W] <= CNT_W'(MAX_POINTS))
      else $error("point count above table size");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[2*PT_W-1:0] == '0)
      else $error("error item carries a non-zero point");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL
         |-> rsp_tdata[RSP_CNT_LSB +: CNT_W] == CNT_W'(MAX_POINTS))
      else $error("table full reported below capacity");

endmodule

bind arc_length_curve_interpolator_unit alci_checker u_alci_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/tb.sv]
// Self-checking testbench for arc_length_curve_interpolator_unit: random and directed items.
// Depends on alci_pkg and the block's RTL; a scoreboard class predicts every result item.
`timescale 1ns / 1ps

module tb;
   import alci_pkg::*;

   typedef struct packed {
      logic [PT_W-1:0]     vre;
      logic [PT_W-1:0]     vim;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    len;
      logic [CNT_W-1:0]    cnt;
   } curve_result_type;

   // Scoreboard: own copy of the point table, running length and range registers.
   class curve_tracker;
      logic signed [PT_W-1:0] pt_re [MAX_POINTS];
      logic signed [PT_W-1:0] pt_im [MAX_POINTS];
      logic [LEN_W-1:0]       cum   [MAX_POINTS];
      int                     count;
      logic [LEN_W-1:0]       run_len;
      logic signed [PT_W-1:0] start_reg;
      logic signed [PT_W-1:0] stop_reg;
      curve_result_type       pending [$];
      int                     errors;

      function new();
         count     = 0;
         run_len   = '0;
         start_reg = '0;
         stop_reg  = RANGE_STOP_RST;
         errors    = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [PT_W-1:0] val);
         if (idx == CSR_RANGE_START) start_reg = val;
         else stop_reg = val;
      endfunction

      // floor(sqrt(v)), one root bit per pass
      function logic [32:0] floor_root(logic [65:0] v);
         logic [32:0] r;
         logic [32:0] t;
         logic [67:0] sq;
         r = '0;
         for (int b = 32; b >= 0; b--) begin
            t  = r | (33'd1 << b);
            sq = {35'd0, t} * {35'd0, t};
            if (sq <= {2'b00, v}) r = t;
         end
         return r;
      endfunction

      // p0 + sign(d) * floor(|d| * num / den)
      function logic [PT_W-1:0] lerp(logic signed [PT_W-1:0] p0, logic signed [PT_W-1:0] p1,
                                     logic [63:0] num, logic [63:0] den);
         logic signed [63:0] d;
         logic [63:0]        mag;
         logic [127:0]       q;
         logic signed [63:0] r;
         d   = 64'(p1) - 64'(p0);
         mag = (d < 0) ? 64'(-d) : 64'(d);
         q   = ({64'd0, mag} * {64'd0, num}) / {64'd0, den};
         r   = (d < 0) ? 64'(p0) - signed'(q[63:0]) : 64'(p0) + signed'(q[63:0]);
         return r[PT_W-1:0];
      endfunction

      function void note_item(opcode_type op, logic signed [PT_W-1:0] re,
                              logic signed [PT_W-1:0] im, logic signed [PT_W-1:0] x);
         curve_result_type   e;
         logic signed [63:0] dx, dy, lo_p, hi_p, t;
         logic [63:0]        ax, ay, s, c0, c1;
         logic [65:0]        sqsum;
         logic [43:0]        sum;
         logic [127:0]       prod;
         int                 a, b, m;
         e = '0;
         e.status = ST_OK;
         case (op)
            OP_APPEND: begin
               if (count >= MAX_POINTS) begin
                  e.status = ST_FULL;
               end else begin
                  if (count > 0) begin
                     dx    = 64'(re) - 64'(pt_re[count-1]);
                     dy    = 64'(im) - 64'(pt_im[count-1]);
                     ax    = (dx < 0) ? 64'(-dx) : 64'(dx);
                     ay    = (dy < 0) ? 64'(-dy) : 64'(dy);
                     sqsum = {2'b00, ax * ax} + {2'b00, ay * ay};
                     sum   = {2'b00, run_len} + 44'(floor_root(sqsum));
                     run_len = (sum > {2'b00, LEN_MAX}) ? LEN_MAX : sum[LEN_W-1:0];
                  end
                  pt_re[count] = re;
                  pt_im[count] = im;
                  cum[count]   = run_len;
                  count++;
               end
            end
            OP_CLEAR: begin
               count   = 0;
               run_len = '0;
            end
            OP_EVAL: begin
               lo_p = 64'(start_reg);
               hi_p = 64'(stop_reg);
               if (hi_p < lo_p) begin
                  t = lo_p; lo_p = hi_p; hi_p = t;
               end
               if (lo_p == hi_p) e.status = ST_SPAN;
               else if (count < 2 || run_len == 0) e.status = ST_FEW;
               else if (64'(x) < lo_p || 64'(x) > hi_p) e.status = ST_RANGE;
               else begin
                  prod = {64'd0, 64'(64'(x) - lo_p)} * {86'd0, run_len};
                  prod = prod / {64'd0, 64'(hi_p - lo_p)};
                  s    = prod[63:0];
                  a = 0;
                  b = count;
                  while (a < b) begin
                     m = a + (b - a) / 2;
                     if (64'(cum[m]) > s) b = m;
                     else a = m + 1;
                  end
                  // parameter at the very end: last point, no read past the table
                  if (a >= count || a == 0) begin
                     e.vre = pt_re[count-1];
                     e.vim = pt_im[count-1];
                  end else begin
                     c0 = 64'(cum[a-1]);
                     c1 = 64'(cum[a]);
                     e.vre = lerp(pt_re[a-1], pt_re[a], s - c0, c1 - c0);
                     e.vim = lerp(pt_im[a-1], pt_im[a], s - c0, c1 - c0);
                  end
               end
            end
            default: ;
         endcase
         e.len = run_len;
         e.cnt = CNT_W'(count);
         pending = {pending, e};
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data, logic [STATUS_W-1:0] st);
         curve_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: result item with nothing expected, status %0d", $time, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[PT_W-1:0] !== e.vre) begin
            $display("%0t: value_real expected %h actual %h", $time, e.vre, data[PT_W-1:0]);
            errors++;
         end
         if (data[2*PT_W-1:PT_W] !== e.vim) begin
            $display("%0t: value_imag expected %h actual %h", $time, e.vim,
                     data[2*PT_W-1:PT_W]);
            errors++;
         end
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (data[RSP_CNT_LSB-1:RSP_LEN_LSB] !== e.len) begin
            $display("%0t: total_length expected %h actual %h", $time, e.len,
                     data[RSP_CNT_LSB-1:RSP_LEN_LSB]);
            errors++;
         end
         if (data[RSP_USED_W-1:RSP_CNT_LSB] !== e.cnt) begin
            $display("%0t: point_count expected %0d actual %0d", $time, e.cnt,
                     data[RSP_USED_W-1:RSP_CNT_LSB]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = OP_NOP;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_RANGE_START;
   logic [PT_W-1:0]        csr_data = '0;

   localparam int IDLE_LIMIT = 20000;   // cycles without any handshake
   localparam int DRAIN_WAIT = 300;     // longer than the slowest evaluate

   curve_tracker curves = new();
   int           burst_left = 4;
   int           idle_cycles = 0;
   int           phase_items;
   int           stall_left = 0;
   int           ready_mode = 0;
   logic signed [PT_W-1:0] last_re = '0, last_im = '0;

   arc_length_curve_interpolator_unit dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Result side: check accepted items, then pick the next ready value.
   // Mode 0 stalls only to end a stall left from mode 2, mode 1 stalls often and briefly, mode 2 holds long stalls.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) curves.check_result(rsp_tdata, rsp_tuser);
      if ($urandom_range(0, 399) == 0) ready_mode <= $urandom_range(0, 2);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (ready_mode == 2 && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(5, 30);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (ready_mode == 1) ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // One item; valid stays high across a burst, may drop for a random gap after it.
   task automatic push_item(opcode_type op, logic [PT_W-1:0] re, logic [PT_W-1:0] im,
                            logic [PT_W-1:0] x);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {x, im, re};
      do @(posedge clock); while (!req_tready);
      curves.note_item(op, re, im, x);
      phase_items++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait until every result is in, plus the block's own latency.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (curves.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [PT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      curves.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Next curve point: mostly small steps, sometimes full-range or extreme values
   function automatic logic [PT_W-1:0] next_coord(logic [PT_W-1:0] prev);
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2:       return prev;
         default: return prev + 32'($signed($urandom_range(0, 8 << FRAC_BITS)) -
                                    (4 << FRAC_BITS));
      endcase
   endfunction

   function automatic logic [PT_W-1:0] pick_param();
      logic signed [63:0] lo_p, hi_p, t;
      lo_p = 64'(curves.start_reg);
      hi_p = 64'(curves.stop_reg);
      if (hi_p < lo_p) begin
         t = lo_p; lo_p = hi_p; hi_p = t;
      end
      case ($urandom_range(0, 11))
         0: return lo_p[PT_W-1:0];
         1: return hi_p[PT_W-1:0];
         2: return (lo_p > -64'sd2147483648) ? 32'(lo_p - 1) : 32'(lo_p);
         3: return (hi_p < 64'sd2147483647) ? 32'(hi_p + 1) : 32'(hi_p);
         4: return $urandom();
         default: return 32'(lo_p + 64'((hi_p - lo_p) * 64'($urandom()) >>> 32));
      endcase
   endfunction

   task automatic append_point(logic [PT_W-1:0] re, logic [PT_W-1:0] im);
      last_re = re;
      last_im = im;
      push_item(OP_APPEND, re, im, $urandom());
   endtask

   task automatic random_phase(int quota, bit fill_table);
      int n;
      phase_items = 0;
      if (fill_table) begin
         // run past the table size so the full case shows, then evaluate
         push_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
         repeat (MAX_POINTS + 3) append_point(next_coord(last_re), next_coord(last_im));
         repeat (10) push_item(OP_EVAL, $urandom(), $urandom(), pick_param());
      end
      while (phase_items < quota) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any opcode, any content
            push_item(opcode_type'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
         end else begin
            push_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
            n = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(2, 12);
            repeat (n) append_point(next_coord(last_re), next_coord(last_im));
            repeat ($urandom_range(3, 10)) push_item(OP_EVAL, $urandom(), $urandom(),
                                                     pick_param());
         end
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty and single-point tables, zero-length curve, extremes, nop
      phase_items = 0;
      push_item(OP_EVAL, '0, '0, '0);
      append_point(32'h0001_0000, 32'h0002_0000);
      push_item(OP_EVAL, '0, '0, 32'h0000_8000);
      append_point(32'h0001_0000, 32'h0002_0000);
      push_item(OP_EVAL, '0, '0, 32'h0000_8000);
      append_point(32'h8000_0000, 32'h8000_0000);
      append_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      append_point(32'h8000_0000, 32'h7FFF_FFFF);
      push_item(OP_EVAL, '0, '0, 32'h0000_0000);
      push_item(OP_EVAL, '0, '0, 32'h0001_0000);
      push_item(OP_EVAL, '0, '0, 32'h0000_4000);
      push_item(OP_EVAL, '0, '0, 32'hFFFF_FFFF);
      push_item(OP_EVAL, '0, '0, 32'h0001_0001);
      push_item(OP_EVAL, '0, '0, 32'h8000_0000);
      push_item(OP_EVAL, '0, '0, 32'h7FFF_FFFF);
      push_item(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(OP_CLEAR, '0, '0, '0);
      push_item(OP_EVAL, '0, '0, '0);
      drain();

      random_phase(250, 1'b1);
      write_reg(CSR_RANGE_START, 32'h8000_0000);
      write_reg(CSR_RANGE_STOP, 32'h7FFF_FFFF);
      random_phase(300, 1'b0);
      // reversed range: the block swaps start and stop
      write_reg(CSR_RANGE_START, 32'h0064_0000);
      write_reg(CSR_RANGE_STOP, 32'hFF9C_0000);
      random_phase(300, 1'b1);
      // equal start and stop
      write_reg(CSR_RANGE_STOP, 32'h0064_0000);
      random_phase(80, 1'b0);
      // narrowest span
      write_reg(CSR_RANGE_START, 32'h7FFF_FFFE);
      write_reg(CSR_RANGE_STOP, 32'h7FFF_FFFF);
      random_phase(250, 1'b0);
      write_reg(CSR_RANGE_START, $urandom());
      write_reg(CSR_RANGE_STOP, $urandom());
      random_phase(300, 1'b0);
      write_reg(CSR_RANGE_START, 32'h0000_0000);
      write_reg(CSR_RANGE_STOP, 32'h0001_0000);
      random_phase(250, 1'b0);

      if (curves.errors == 0 && curves.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
